// File: rtl/core/mfmc_pkg.sv
package mfmc_pkg;

    // Default sizes of the graph store.
    localparam int MAX_VERTICES_DEF = 32;
    localparam int CAP_WIDTH_DEF    = 16;

    // Fixed field widths at the ports.
    localparam int KIND_W   = 2;
    localparam int VTX_W    = 5;
    localparam int CAPIN_W  = 16;
    localparam int FLOW_W   = 21;
    localparam int MASK_W   = 32;
    localparam int VCOUNT_W = 6;
    localparam int SDATA_W  = 32;
    localparam int MDATA_W  = 56;

    localparam logic [FLOW_W-1:0]   FLOW_LIMIT    = 21'h1FFFFF;
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET  = 6'd32;

    // Item kinds carried in the slave-side tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_DFS_INIT,
        ST_DFS_POP,
        ST_DFS_SCAN,
        ST_NECK_RD,
        ST_NECK_CMP,
        ST_FWD_RD,
        ST_FWD_WR,
        ST_REV_RD,
        ST_REV_WR,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/max_flow_min_cut_top.sv
// Max flow / min cut engine, Ford-Fulkerson with a stack depth-first search.
// Edge load reads the capacity row, then writes it back. Clear and unknown kinds are taken in idle.
// Run: copy every capacity row into the residual rows, then per search scan each popped vertex's
// row in neighbor order, and walk each found path twice, for the bottleneck and for the update.
// One item at a time; the result waits in an output register while the next item is taken.
// Reset is asynchronous: the capacity matrix reads as zero through per-row valid bits.
module max_flow_min_cut_top #(
    parameter int MAX_VERTICES = mfmc_pkg::MAX_VERTICES_DEF,
    parameter int CAP_WIDTH    = mfmc_pkg::CAP_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mfmc_pkg::VCOUNT_W-1:0]    cfg_wdata,   // vertex_count
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mfmc_pkg::SDATA_W-1:0]     s_tdata,     // from_vertex, to_vertex, capacity
    input  logic [mfmc_pkg::KIND_W-1:0]      s_tuser,     // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mfmc_pkg::MDATA_W-1:0]     m_tdata      // total_flow, source_side_mask
);

    localparam int VW        = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
    localparam int RES_W     = CAP_WIDTH + 1;
    localparam int CAP_ROW_W = MAX_VERTICES * CAP_WIDTH;
    localparam int RES_ROW_W = MAX_VERTICES * RES_W;
    localparam int TOT_W     = CAP_WIDTH + VW + 1;
    localparam int CMP_W     = (TOT_W > mfmc_pkg::FLOW_W) ? TOT_W : mfmc_pkg::FLOW_W;
    localparam logic [6:0]  MAXV7    = 7'(MAX_VERTICES);
    localparam logic [VW:0] TOP_FULL = (VW + 1)'(MAX_VERTICES);
    localparam logic [VW-1:0] ROW_LAST = VW'(MAX_VERTICES - 1);

    // Input fields.
    logic [mfmc_pkg::VTX_W-1:0]   in_from;
    logic [mfmc_pkg::VTX_W-1:0]   in_to;
    logic [mfmc_pkg::CAPIN_W-1:0] in_cap;
    mfmc_pkg::kind_t              in_kind;
    logic [6:0]                   from7;
    logic [6:0]                   to7;

    assign in_from = s_tdata[4:0];
    assign in_to   = s_tdata[9:5];
    assign in_cap  = s_tdata[25:10];
    assign in_kind = mfmc_pkg::kind_t'(s_tuser);
    assign from7   = 7'(in_from);
    assign to7     = 7'(in_to);

    // Control and working registers.
    mfmc_pkg::state_t             state_reg, state_next;
    logic [mfmc_pkg::VCOUNT_W-1:0] vc_reg;
    logic [MAX_VERTICES-1:0]      cap_vld_reg;
    logic [MAX_VERTICES-1:0]      visited_reg, visited_next;
    logic [VW:0]                  top_reg, top_next;
    logic [VW-1:0]                v_reg, v_next;
    logic [VW-1:0]                u_reg, u_next;
    logic [VW-1:0]                s_reg, s_next;
    logic [mfmc_pkg::VTX_W-1:0]   t_reg, t_next;
    logic [VW-1:0]                sink_reg, sink_next;
    logic [VW-1:0]                walk_v_reg, walk_v_next;
    logic [VW-1:0]                walk_u_reg, walk_u_next;
    logic [VW-1:0]                cnt_reg, cnt_next;
    logic [CAP_WIDTH-1:0]         lcap_reg, lcap_next;
    logic [RES_W-1:0]             neck_reg, neck_next;
    logic [TOT_W-1:0]             total_reg, total_next;
    logic                         reach_reg, reach_next;
    logic                         m_tvalid_reg;
    logic [mfmc_pkg::FLOW_W-1:0]  flow_out_reg;
    logic [mfmc_pkg::MASK_W-1:0]  mask_out_reg;

    // Search stack and path parents.
    logic [VW-1:0] stack_reg  [MAX_VERTICES];
    logic [VW-1:0] parent_reg [MAX_VERTICES];

    // Strobes from the sequencer.
    logic          push_en;
    logic [VW-1:0] push_addr;
    logic [VW-1:0] push_data;
    logic          parent_we;
    logic          clear_vld;
    logic          set_vld;
    logic          out_load;

    // Memory ports.
    logic                                  cap_we, cap_re;
    logic [VW-1:0]                         cap_waddr, cap_raddr;
    logic [MAX_VERTICES-1:0][CAP_WIDTH-1:0] cap_wdata, cap_q;
    logic                                  res_we, res_re;
    logic [VW-1:0]                         res_waddr, res_raddr;
    logic [MAX_VERTICES-1:0][RES_W-1:0]    res_wdata, res_q;
    logic [CAP_ROW_W-1:0]                  cap_q_flat;
    logic [RES_ROW_W-1:0]                  res_q_flat;

    assign cap_q = cap_q_flat;
    assign res_q = res_q_flat;

    mfmc_row_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (CAP_ROW_W)
    ) u_cap_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (CAP_ROW_W'(cap_wdata)),
        .re    (cap_re),
        .raddr (cap_raddr),
        .rdata (cap_q_flat)
    );

    mfmc_row_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (RES_ROW_W)
    ) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (RES_ROW_W'(res_wdata)),
        .re    (res_re),
        .raddr (res_raddr),
        .rdata (res_q_flat)
    );

    // Effective vertex count, clamped to the range one to MAX_VERTICES.
    logic [6:0] n_eff;
    logic [6:0] vc7;

    assign vc7   = 7'(vc_reg);
    assign n_eff = (vc7 == 7'd0) ? 7'd1 : ((vc7 > MAXV7) ? MAXV7 : vc7);

    // Scan helpers.
    logic [VW:0]   top_m1;
    logic          scan_hit;
    logic          scan_last;
    logic          scan_sink;

    assign top_m1    = top_reg - (VW + 1)'(1);
    assign scan_hit  = !visited_reg[v_reg] && (res_q[v_reg] != '0);
    assign scan_last = (7'(v_reg) == (n_eff - 7'd1));
    assign scan_sink = (7'(v_reg) == 7'(t_reg));

    // Sequencer: next state, memory accesses and working registers.
    always_comb
    begin
        state_next   = state_reg;
        visited_next = visited_reg;
        top_next     = top_reg;
        v_next       = v_reg;
        u_next       = u_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        sink_next    = sink_reg;
        walk_v_next  = walk_v_reg;
        walk_u_next  = walk_u_reg;
        cnt_next     = cnt_reg;
        lcap_next    = lcap_reg;
        neck_next    = neck_reg;
        total_next   = total_reg;
        reach_next   = reach_reg;

        push_en   = 1'b0;
        push_addr = top_reg[VW-1:0];
        push_data = v_reg;
        parent_we = 1'b0;
        clear_vld = 1'b0;
        set_vld   = 1'b0;
        out_load  = 1'b0;

        cap_we    = 1'b0;
        cap_re    = 1'b0;
        cap_waddr = s_reg;
        cap_raddr = cnt_reg;
        cap_wdata = cap_q;
        res_we    = 1'b0;
        res_re    = 1'b0;
        res_waddr = walk_u_reg;
        res_raddr = u_reg;
        res_wdata = res_q;

        s_tready = (state_reg == mfmc_pkg::ST_IDLE);

        case (state_reg)
            mfmc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_kind)
                        mfmc_pkg::KIND_LOAD:
                        begin
                            if ((from7 < MAXV7) && (to7 < MAXV7))
                            begin
                                cap_re      = 1'b1;
                                cap_raddr   = from7[VW-1:0];
                                s_next      = from7[VW-1:0];
                                walk_v_next = to7[VW-1:0];
                                lcap_next   = CAP_WIDTH'(in_cap);
                                state_next  = mfmc_pkg::ST_LOAD_WR;
                            end
                        end
                        mfmc_pkg::KIND_CLEAR:
                        begin
                            clear_vld = 1'b1;
                        end
                        mfmc_pkg::KIND_RUN:
                        begin
                            s_next     = from7[VW-1:0];
                            t_next     = in_to;
                            total_next = '0;
                            reach_next = 1'b0;
                            if (from7 < n_eff)
                            begin
                                cnt_next   = '0;
                                state_next = mfmc_pkg::ST_COPY_RD;
                            end
                            else
                            begin
                                visited_next = '0;
                                state_next   = mfmc_pkg::ST_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Write back the loaded row; a row never written since clear reads as zero.
            mfmc_pkg::ST_LOAD_WR:
            begin
                cap_we    = 1'b1;
                cap_waddr = s_reg;
                cap_wdata = cap_vld_reg[s_reg] ? cap_q : '0;
                cap_wdata[walk_v_reg] = lcap_reg;
                set_vld    = 1'b1;
                state_next = mfmc_pkg::ST_IDLE;
            end

            mfmc_pkg::ST_COPY_RD:
            begin
                cap_re     = 1'b1;
                cap_raddr  = cnt_reg;
                state_next = mfmc_pkg::ST_COPY_WR;
            end

            mfmc_pkg::ST_COPY_WR:
            begin
                res_we    = 1'b1;
                res_waddr = cnt_reg;
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    res_wdata[i] = cap_vld_reg[cnt_reg] ? RES_W'(cap_q[i]) : '0;
                end
                if (cnt_reg == ROW_LAST)
                begin
                    state_next = mfmc_pkg::ST_DFS_INIT;
                end
                else
                begin
                    cnt_next   = cnt_reg + VW'(1);
                    state_next = mfmc_pkg::ST_COPY_RD;
                end
            end

            // Start a search with only the source marked and on the stack.
            mfmc_pkg::ST_DFS_INIT:
            begin
                visited_next        = '0;
                visited_next[s_reg] = 1'b1;
                push_en    = 1'b1;
                push_addr  = '0;
                push_data  = s_reg;
                top_next   = (VW + 1)'(1);
                state_next = mfmc_pkg::ST_DFS_POP;
            end

            mfmc_pkg::ST_DFS_POP:
            begin
                if (top_reg == '0)
                begin
                    if (reach_reg)
                    begin
                        state_next = mfmc_pkg::ST_DONE;
                    end
                    else
                    begin
                        reach_next = 1'b1;
                        state_next = mfmc_pkg::ST_DFS_INIT;
                    end
                end
                else
                begin
                    u_next     = stack_reg[top_m1[VW-1:0]];
                    top_next   = top_m1;
                    res_re     = 1'b1;
                    res_raddr  = stack_reg[top_m1[VW-1:0]];
                    v_next     = '0;
                    state_next = mfmc_pkg::ST_DFS_SCAN;
                end
            end

            // One neighbor per cycle in ascending order.
            mfmc_pkg::ST_DFS_SCAN:
            begin
                if (scan_hit)
                begin
                    visited_next[v_reg] = 1'b1;
                    if (top_reg < TOP_FULL)
                    begin
                        push_en  = 1'b1;
                        top_next = top_reg + (VW + 1)'(1);
                    end
                    parent_we = !reach_reg;
                end
                if (scan_hit && !reach_reg && scan_sink)
                begin
                    sink_next   = v_reg;
                    walk_v_next = v_reg;
                    neck_next   = '1;
                    state_next  = mfmc_pkg::ST_NECK_RD;
                end
                else if (scan_last)
                begin
                    state_next = mfmc_pkg::ST_DFS_POP;
                end
                else
                begin
                    v_next = v_reg + VW'(1);
                end
            end

            // Walk the parents from the sink for the bottleneck.
            mfmc_pkg::ST_NECK_RD:
            begin
                if (walk_v_reg == s_reg)
                begin
                    walk_v_next = sink_reg;
                    state_next  = mfmc_pkg::ST_FWD_RD;
                end
                else
                begin
                    walk_u_next = parent_reg[walk_v_reg];
                    res_re      = 1'b1;
                    res_raddr   = parent_reg[walk_v_reg];
                    state_next  = mfmc_pkg::ST_NECK_CMP;
                end
            end

            mfmc_pkg::ST_NECK_CMP:
            begin
                if (res_q[walk_v_reg] < neck_reg)
                begin
                    neck_next = res_q[walk_v_reg];
                end
                walk_v_next = walk_u_reg;
                state_next  = mfmc_pkg::ST_NECK_RD;
            end

            // Second walk: lower the forward edge, raise the reverse edge.
            mfmc_pkg::ST_FWD_RD:
            begin
                if (walk_v_reg == s_reg)
                begin
                    total_next = total_reg + TOT_W'(neck_reg);
                    state_next = mfmc_pkg::ST_DFS_INIT;
                end
                else
                begin
                    walk_u_next = parent_reg[walk_v_reg];
                    res_re      = 1'b1;
                    res_raddr   = parent_reg[walk_v_reg];
                    state_next  = mfmc_pkg::ST_FWD_WR;
                end
            end

            mfmc_pkg::ST_FWD_WR:
            begin
                res_we    = 1'b1;
                res_waddr = walk_u_reg;
                res_wdata[walk_v_reg] = res_q[walk_v_reg] - neck_reg;
                state_next = mfmc_pkg::ST_REV_RD;
            end

            mfmc_pkg::ST_REV_RD:
            begin
                res_re     = 1'b1;
                res_raddr  = walk_v_reg;
                state_next = mfmc_pkg::ST_REV_WR;
            end

            mfmc_pkg::ST_REV_WR:
            begin
                res_we    = 1'b1;
                res_waddr = walk_v_reg;
                res_wdata[walk_u_reg] = res_q[walk_u_reg] + neck_reg;
                walk_v_next = walk_u_reg;
                state_next  = mfmc_pkg::ST_FWD_RD;
            end

            // Hand the result to the output register once it is free.
            mfmc_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = mfmc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mfmc_pkg::ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg       <= mfmc_pkg::VCOUNT_RESET;
            cap_vld_reg  <= '0;
            visited_reg  <= '0;
            top_reg      <= '0;
            total_reg    <= '0;
            reach_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
            if (clear_vld)
            begin
                cap_vld_reg <= '0;
            end
            else if (set_vld)
            begin
                cap_vld_reg[s_reg] <= 1'b1;
            end
            visited_reg <= visited_next;
            top_reg     <= top_next;
            total_reg   <= total_next;
            reach_reg   <= reach_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers without reset.
    logic [CMP_W-1:0] total_ext;
    logic [63:0]      visited_wide;

    assign total_ext    = CMP_W'(total_reg);
    assign visited_wide = 64'(visited_reg);

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        u_reg      <= u_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        sink_reg   <= sink_next;
        walk_v_reg <= walk_v_next;
        walk_u_reg <= walk_u_next;
        cnt_reg    <= cnt_next;
        lcap_reg   <= lcap_next;
        neck_reg   <= neck_next;
        if (push_en)
        begin
            stack_reg[push_addr] <= push_data;
        end
        if (parent_we)
        begin
            parent_reg[v_reg] <= u_reg;
        end
        if (out_load)
        begin
            flow_out_reg <= (total_ext > CMP_W'(mfmc_pkg::FLOW_LIMIT)) ?
                            mfmc_pkg::FLOW_LIMIT : total_ext[mfmc_pkg::FLOW_W-1:0];
            mask_out_reg <= visited_wide[mfmc_pkg::MASK_W-1:0];
        end
    end

    // Result transaction.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, mask_out_reg, flow_out_reg};

    // The stack never holds more than MAX_VERTICES entries.
    assert property (@(posedge clk) disable iff (!rst_n) top_reg <= TOP_FULL)
        else $error("search stack overflow");

    // Every edge on a found path has positive residual.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mfmc_pkg::ST_NECK_CMP) |-> (res_q[walk_v_reg] != '0))
        else $error("zero residual on augmenting path");

    // A finished run is presented on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && (state_reg == mfmc_pkg::ST_IDLE)))
        else $error("result not presented");

endmodule

// File: rtl/core/mfmc_row_ram.sv
module mfmc_row_ram #(
    parameter int DEPTH = mfmc_pkg::MAX_VERTICES_DEF,
    parameter int WIDTH = mfmc_pkg::CAP_WIDTH_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // One read port with registered data; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
